// ===== design/slc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache lookup core.
`default_nettype none

package slc_pkg;

    // Field and register widths fixed by the interface.
    localparam int ADDR_IN_W  = 32;
    localparam int OFFSET_W   = 5;
    localparam int INDEX_W    = 4;
    localparam int WAYS_W     = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;

    // Widest set index that index_bits can select (index_bits of at most 15).
    localparam int IDX_W      = 15;
    localparam int WAY_IDX_W  = 3;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;

    // Result payload: hit, way_used, access_total, hit_total, padded to bytes.
    localparam int RES_W      = 1 + WAY_IDX_W + CNT_W + CNT_W;
    localparam int OUT_W      = ((RES_W + 7) / 8) * 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAYS        = 2'd2;

    // Configuration reset values.
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 5'd2;
    localparam logic [INDEX_W-1:0]  INDEX_RST  = 4'd0;
    localparam logic [WAYS_W-1:0]   WAYS_RST   = 4'd1;

    // Running result of the way scan of one set.
    typedef struct packed {
        logic                 hit_found;
        logic [WAY_IDX_W-1:0] hit_way;
        logic                 empty_found;
        logic [WAY_IDX_W-1:0] empty_way;
        logic                 best_found;
        logic [STAMP_W-1:0]   best_stamp;
        logic [WAY_IDX_W-1:0] best_way;
    } scan_t;

endpackage

`default_nettype wire

// ===== design/slc_addr_split.sv =====
// Address splitter: block address and raw set index from a byte address.
`default_nettype none

module slc_addr_split
    import slc_pkg::*;
#(
    parameter int TAG_W = 32
)
(
    input  wire logic [ADDR_IN_W-1:0] address,
    input  wire logic [OFFSET_W-1:0]  offset_bits,
    input  wire logic [INDEX_W-1:0]   index_bits,
    output logic      [TAG_W-1:0]     block,
    output logic      [IDX_W-1:0]     idx
);

    logic [IDX_W-1:0] idx_mask;

    // Taking the low TAG_W bits drops address bits above the address width.
    assign block    = address[TAG_W-1:0] >> offset_bits;
    assign idx_mask = ~({IDX_W{1'b1}} << index_bits);
    assign idx      = block[IDX_W-1:0] & idx_mask;

endmodule

`default_nettype wire

// ===== design/slc_way_cmp.sv =====
// Way compare unit: folds one stored entry into the running scan of a set.
`default_nettype none

module slc_way_cmp
    import slc_pkg::*;
#(
    parameter int TAG_W = 32
)
(
    input  wire logic                 entry_valid,
    input  wire logic [TAG_W-1:0]     entry_tag,
    input  wire logic [STAMP_W-1:0]   entry_stamp,
    input  wire logic [WAY_IDX_W-1:0] way,
    input  wire logic [TAG_W-1:0]     block,
    input  wire scan_t                scan_in,
    output scan_t                     scan_out
);

    always_comb
    begin
        scan_out = scan_in;
        // The first matching valid way is the hit.
        if (!scan_in.hit_found && entry_valid && (entry_tag == block))
        begin
            scan_out.hit_found = 1'b1;
            scan_out.hit_way   = way;
        end
        // The lowest invalid way is the preferred victim.
        if (!scan_in.empty_found && !entry_valid)
        begin
            scan_out.empty_found = 1'b1;
            scan_out.empty_way   = way;
        end
        // Oldest stamp among valid ways; a strict compare keeps the lowest way on ties.
        if (entry_valid && (!scan_in.best_found || (entry_stamp < scan_in.best_stamp)))
        begin
            scan_out.best_found = 1'b1;
            scan_out.best_stamp = entry_stamp;
            scan_out.best_way   = way;
        end
    end

endmodule

`default_nettype wire

// ===== design/set_assoc_lru_cache_lookup_core.sv =====
// Top level of the set-associative LRU cache lookup core.
`default_nettype none

// Set-associative cache lookup with least-recently-used replacement. Each input
// transaction carries one byte address; the core splits it into block offset, set
// index and tag under the offset_bits, index_bits and ways registers, looks the block
// up in the ways of that set and returns one result transaction with hit, the way
// used and saturating running access and hit counts. On a miss the lowest invalid
// way is filled, otherwise the way with the oldest stamp (lowest way on ties). All
// tags, valid bits and stamps sit in one single-port-write memory of MAX_SETS *
// MAX_WAYS entries, one entry per way, read one way per cycle through a single
// compare unit. An item goes through these steps from acceptance to its result:
// accept and split the address, reduce the index modulo MAX_SETS with a constant
// reciprocal multiply in states ST_MOD1 and ST_MOD2, one memory read per way in use,
// fold the last read way into the scan, and write back. s_tready is high only between
// items. After reset the core clears the memory one entry per cycle, all MAX_SETS *
// MAX_WAYS entries, and accepts no address until the pass is done; configuration
// writes are taken at any time, with cfg_ready always high, but the registers should
// only be changed while no item is in flight. Stored contents survive a change of
// geometry. The result sits in an output register, so the next address is accepted
// while an earlier result still waits for m_tready.
module set_assoc_lru_cache_lookup_core
    import slc_pkg::*;
#(
    parameter int MAX_SETS   = 1024,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Address stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [ADDR_IN_W-1:0]  s_tdata,   // [31:0] address
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_W-1:0]      m_tdata    // [0] hit, [3:1] way_used,
                                                  // [35:4] access_total,
                                                  // [67:36] hit_total, rest zero
);

    // Stored block address width: addresses are 32 bits at most.
    localparam int TAG_W   = (ADDR_WIDTH < ADDR_IN_W) ? ADDR_WIDTH : ADDR_IN_W;
    localparam int ENTRIES = MAX_SETS * MAX_WAYS;
    localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

    // Exact quotient idx / MAX_SETS for any idx below 2**IDX_W by a rounded-up
    // reciprocal: q = (idx * MOD_M) >> MOD_SH.
    localparam int MOD_L   = $clog2(MAX_SETS);
    localparam int MOD_SH  = IDX_W + MOD_L;
    localparam int MOD_M_W = IDX_W + 2;
    localparam int PROD_W  = IDX_W + MOD_M_W;
    localparam longint unsigned MOD_M_FULL =
        ((64'd1 << MOD_SH) + 64'(MAX_SETS) - 64'd1) / 64'(MAX_SETS);
    localparam logic [MOD_M_W-1:0] MOD_M = MOD_M_W'(MOD_M_FULL);

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MOD1  = 7'b0000100,
        ST_MOD2  = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_LAST  = 7'b0100000,
        ST_WRITE = 7'b1000000
    } state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

    state_t                 state_reg, state_next;
    logic [ENT_W-1:0]       clr_addr_reg;

    logic [OFFSET_W-1:0]    offset_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic [WAYS_W-1:0]      ways_reg;

    logic [TAG_W-1:0]       split_block;
    logic [IDX_W-1:0]       split_idx;
    logic [TAG_W-1:0]       block_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [WAY_IDX_W-1:0]   last_way_reg, last_way_calc;
    logic [PROD_W-1:0]      prod_reg;
    logic [IDX_W-1:0]       quot;
    logic [PROD_W-1:0]      quot_times_sets;
    logic [IDX_W-1:0]       rem;
    logic [SET_W-1:0]       set_reg;

    logic [WAY_IDX_W-1:0]   rd_way_reg;
    logic [WAY_IDX_W-1:0]   cmp_way_reg;
    logic                   cmp_en_reg;
    scan_t                  scan_reg, scan_next;
    logic [WAY_IDX_W-1:0]   final_way;

    entry_t                 mem [ENTRIES];
    entry_t                 rd_data_reg;
    logic                   mem_we;
    logic [ENT_W-1:0]       mem_waddr, mem_raddr;
    entry_t                 mem_wdata;

    logic [CNT_W-1:0]       acc_cnt_reg, hit_cnt_reg;
    logic [CNT_W-1:0]       acc_next, hit_next;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic                   out_stall;
    logic                   commit;

    // Configuration registers; indexes beyond the list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RST;
            index_reg  <= INDEX_RST;
            ways_reg   <= WAYS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_OFFSET_BITS: offset_reg <= cfg_data;
                CFG_INDEX_BITS:  index_reg  <= cfg_data[INDEX_W-1:0];
                CFG_WAYS:        ways_reg   <= cfg_data[WAYS_W-1:0];
                default:         ;
            endcase
        end
    end

    slc_addr_split #(
        .TAG_W(TAG_W)
    ) u_split (
        .address    (s_tdata),
        .offset_bits(offset_reg),
        .index_bits (index_reg),
        .block      (split_block),
        .idx        (split_idx)
    );

    // A ways value of zero acts as one way; values above MAX_WAYS act as MAX_WAYS.
    always_comb
    begin
        if (ways_reg == '0)
            last_way_calc = '0;
        else if (ways_reg > WAYS_W'(MAX_WAYS))
            last_way_calc = WAY_IDX_W'(MAX_WAYS - 1);
        else
            last_way_calc = WAY_IDX_W'(ways_reg - WAYS_W'(1));
    end

    // Second half of the set-index reduction; prod_reg is registered before the
    // multiply by MAX_SETS.
    assign quot            = IDX_W'(prod_reg >> MOD_SH);
    assign quot_times_sets = PROD_W'(quot) * PROD_W'(MAX_SETS);
    assign rem             = idx_reg - quot_times_sets[IDX_W-1:0];

    // The single compare unit, fed one way per cycle from the memory read register.
    slc_way_cmp #(
        .TAG_W(TAG_W)
    ) u_cmp (
        .entry_valid(rd_data_reg.valid),
        .entry_tag  (rd_data_reg.tag),
        .entry_stamp(rd_data_reg.stamp),
        .way        (cmp_way_reg),
        .block      (block_reg),
        .scan_in    (scan_reg),
        .scan_out   (scan_next)
    );

    always_comb
    begin
        if (scan_reg.hit_found)
            final_way = scan_reg.hit_way;
        else if (scan_reg.empty_found)
            final_way = scan_reg.empty_way;
        else
            final_way = scan_reg.best_way;
    end

    // The write-back waits while an earlier result still sits unclaimed.
    assign out_stall = m_tvalid_reg && !m_tready;
    assign commit    = (state_reg == ST_WRITE) && !out_stall;

    assign acc_next = sat_inc(acc_cnt_reg);
    assign hit_next = scan_reg.hit_found ? sat_inc(hit_cnt_reg) : hit_cnt_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_addr_reg == ENT_W'(ENTRIES - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_MOD1;
            ST_MOD1:
                state_next = ST_MOD2;
            ST_MOD2:
                state_next = ST_READ;
            ST_READ:
                if (rd_way_reg == last_way_reg)
                    state_next = ST_LAST;
            ST_LAST:
                state_next = ST_WRITE;
            ST_WRITE:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_way_reg   <= '0;
            cmp_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cmp_en_reg <= (state_reg == ST_READ);
            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + ENT_W'(1);
            if (state_reg == ST_MOD2)
                rd_way_reg <= '0;
            else if (state_reg == ST_READ)
                rd_way_reg <= rd_way_reg + WAY_IDX_W'(1);
        end
    end

    // Datapath registers of the item in flight.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            block_reg    <= split_block;
            idx_reg      <= split_idx;
            last_way_reg <= last_way_calc;
        end
        if (state_reg == ST_MOD1)
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(MOD_M);
        if (state_reg == ST_MOD2)
        begin
            set_reg  <= SET_W'(rem);
            scan_reg <= '0;
        end
        else if (cmp_en_reg)
            scan_reg <= scan_next;
        cmp_way_reg <= rd_way_reg;
    end

    // Entry memory: one write port, one registered read port.
    assign mem_raddr = ENT_W'(set_reg) * ENT_W'(MAX_WAYS) + ENT_W'(rd_way_reg);
    assign mem_we    = (state_reg == ST_CLEAR) || commit;
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg
                     : ENT_W'(set_reg) * ENT_W'(MAX_WAYS) + ENT_W'(final_way);

    always_comb
    begin
        if (state_reg == ST_CLEAR)
            mem_wdata = '0;
        else
        begin
            mem_wdata.valid = 1'b1;
            mem_wdata.tag   = block_reg;
            mem_wdata.stamp = acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Running counts and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg  <= '0;
            hit_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                acc_cnt_reg  <= acc_next;
                hit_cnt_reg  <= hit_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            m_tdata_reg <= OUT_W'({hit_next, acc_next, final_way, scan_reg.hit_found});
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Hits can never outnumber accesses.
    assert property (@(posedge clk) disable iff (!rst_n)
        hit_cnt_reg <= acc_cnt_reg)
        else $error("hit count exceeds access count");

    // The way written back always lies among the ways in use.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (final_way <= last_way_reg))
        else $error("chosen way outside the active ways");

    // A write-back presents its result with the updated access count next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (m_tvalid && (m_tdata[35:4] == acc_cnt_reg)))
        else $error("result not presented after write-back");

endmodule

`default_nettype wire
